// File: src/lfps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfps_pkg - shared types and constants for the line-follow steering controller
// Register map codes, register reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package lfps_pkg;

  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 8;
  localparam int ANGLE_W    = 8;
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [2:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_ANGLE_LIMIT    = 3'd4,
    REG_STRAIGHT_ANGLE = 3'd5
  } reg_idx_t;

  localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 16'sd819;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 16'sd0;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 16'sd2458;
  localparam logic [LIM_W-1:0]         ILIM_RST   = 8'd50;
  localparam logic [LIM_W-1:0]         ALIM_RST   = 8'd30;
  localparam logic [ANGLE_W-1:0]       BASE_RST   = 8'd90;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [LIM_W-1:0]         integral_limit;
    logic [LIM_W-1:0]         angle_limit;
    logic [ANGLE_W-1:0]       straight_angle;
  } cfg_t;

endpackage
`default_nettype wire

// File: src/lfps_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfps_front - input stage
// Accepts measurements, forms error and position delta, tracks last position.
// ----------------------------------------------------------------------------
module lfps_front import lfps_pkg::*; #(
  parameter int POS_BITS = 10
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                line_seen,
  input  wire logic [POS_BITS-1:0] position,
  input  wire logic [POS_BITS-1:0] target,
  input  wire logic                q_full,
  output logic                     q_push,
  output logic [2*POS_BITS+2:0]    q_data      // err, delta, line_seen
);

  logic [POS_BITS-1:0]       last_pos_r, last_pos_nxt;
  logic                      known_r, known_nxt;
  logic signed [POS_BITS:0]  err;
  logic signed [POS_BITS:0]  delta;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    err   = $signed({1'b0, target}) - $signed({1'b0, position});
    delta = known_r ? ($signed({1'b0, position}) - $signed({1'b0, last_pos_r}))
                    : '0;
    last_pos_nxt = last_pos_r;
    known_nxt    = known_r;
    if (q_push && line_seen) begin
      last_pos_nxt = position;
      known_nxt    = 1'b1;
    end
  end

  assign q_data = {line_seen, delta, err};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pos_r <= '0;
      known_r    <= 1'b0;
    end else begin
      last_pos_r <= last_pos_nxt;
      known_r    <= known_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/lfps_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfps_fifo - small synchronous queue
// Decouples the input stage from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module lfps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  full,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [AW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fifo count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && cnt_r != CW'(DEPTH)) |-> (wp_r != rp_r))
    else $error("fifo pointers collide while partly filled");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("fifo count not decremented on pop");

endmodule
`default_nettype wire

// File: src/lfps_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfps_back - PID arithmetic pipeline
// Products, integral update and clamp, correction clamp, base offset, floor and saturate.
// ----------------------------------------------------------------------------
module lfps_back import lfps_pkg::*; #(
  parameter int POS_BITS  = 10,
  parameter int FRAC_BITS = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cfg_t                 cfg,
  input  wire logic                 q_empty,
  input  wire logic [2*POS_BITS+2:0] q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [ANGLE_W-1:0]        steer_angle
);

  localparam int EW  = POS_BITS + 1;
  localparam int PW  = EW + GAIN_W;
  localparam int IW  = FRAC_BITS + LIM_W + 1;
  localparam int TW  = ((PW > IW) ? PW : IW) + 1;
  localparam int SW  = (((PW + 1) > IW) ? (PW + 1) : IW) + 1;
  localparam int CW  = FRAC_BITS + LIM_W + 1;
  localparam int AW  = FRAC_BITS + LIM_W + 3;
  localparam int FW  = AW - FRAC_BITS;

  logic                  adv;
  logic                  in_seen;
  logic signed [EW-1:0]  in_err, in_delta;

  logic                  v1_r, s1_r;
  logic signed [PW-1:0]  pe_r, ie_r, de_r;

  logic                  v2_r, s2_r;
  logic signed [PW:0]    pd_r;
  logic signed [IW-1:0]  i2_r;
  logic signed [IW-1:0]  integ_r, integ_nxt;

  logic                  v3_r, s3_r;
  logic signed [CW-1:0]  cs_r;

  logic                  ov_r;
  logic [ANGLE_W-1:0]    oang_r;

  logic signed [TW-1:0]  itmp, ilim;
  logic signed [SW-1:0]  stmp, alim;
  logic signed [CW-1:0]  cs_nxt;
  logic signed [AW-1:0]  asum;
  logic signed [FW-1:0]  afl;
  logic [ANGLE_W-1:0]    oang_nxt;

  assign adv   = !ov_r || out_ready;
  assign q_pop = adv && !q_empty;
  assign {in_seen, in_delta, in_err} = q_data;

  assign out_valid   = ov_r;
  assign steer_angle = oang_r;

  // integral accumulate and clamp
  always_comb begin
    ilim = $signed(TW'({cfg.integral_limit, {FRAC_BITS{1'b0}}}));
    itmp = TW'(integ_r) + TW'(ie_r);
    if (itmp > ilim) begin
      integ_nxt = IW'(ilim);
    end else if (itmp < -ilim) begin
      integ_nxt = IW'(-ilim);
    end else begin
      integ_nxt = IW'(itmp);
    end
  end

  // correction clamp
  always_comb begin
    alim = $signed(SW'({cfg.angle_limit, {FRAC_BITS{1'b0}}}));
    stmp = SW'(pd_r) + SW'(i2_r);
    if (stmp > alim) begin
      cs_nxt = CW'(alim);
    end else if (stmp < -alim) begin
      cs_nxt = CW'(-alim);
    end else begin
      cs_nxt = CW'(stmp);
    end
  end

  // base offset, floor, saturate
  always_comb begin
    asum = AW'(cs_r) + $signed(AW'({cfg.straight_angle, {FRAC_BITS{1'b0}}}));
    afl  = FW'(asum >>> FRAC_BITS);
    if (!s3_r) begin
      oang_nxt = cfg.straight_angle;
    end else if (afl < 0) begin
      oang_nxt = '0;
    end else if (afl > $signed(FW'(255))) begin
      oang_nxt = '1;
    end else begin
      oang_nxt = afl[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      ov_r    <= 1'b0;
      integ_r <= '0;
    end else if (adv) begin
      v1_r <= !q_empty;
      v2_r <= v1_r;
      v3_r <= v2_r;
      ov_r <= v3_r;
      if (v1_r && s1_r) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r   <= in_seen;
      pe_r   <= PW'(in_err) * PW'(cfg.gain_p);
      ie_r   <= PW'(in_err) * PW'(cfg.gain_i);
      de_r   <= PW'(in_delta) * PW'(cfg.gain_d);
      s2_r   <= s1_r;
      pd_r   <= (PW + 1)'(pe_r) + (PW + 1)'(de_r);
      i2_r   <= integ_nxt;
      s3_r   <= s2_r;
      cs_r   <= cs_nxt;
      oang_r <= oang_nxt;
    end
  end

  a_integ_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && s2_r) |->
      (i2_r <= $signed(IW'({cfg.integral_limit, {FRAC_BITS{1'b0}}})) &&
       i2_r >= -$signed(IW'({cfg.integral_limit, {FRAC_BITS{1'b0}}}))))
    else $error("integral outside its clamp");

  a_corr_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && s3_r) |->
      (cs_r <= $signed(CW'({cfg.angle_limit, {FRAC_BITS{1'b0}}})) &&
       cs_r >= -$signed(CW'({cfg.angle_limit, {FRAC_BITS{1'b0}}}))))
    else $error("correction outside its clamp");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(v1_r) && $stable(v2_r) && $stable(v3_r) && $stable(integ_r)))
    else $error("pipeline moved during output stall");

endmodule
`default_nettype wire

// File: src/line_follow_pid_steering.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_follow_pid_steering - PID steering controller for line following
// Takes one measurement per cycle while the queue has room and returns one
// steering angle per measurement. The result passes through the queue, the
// product stage, the integral stage and the clamp stage and is then held in
// the output register. Throughput, set by the integral update loop, is one
// transaction per cycle while the output is not stalled. A four-entry queue
// behind the input stage absorbs output stalls.
// Registers (byte address 4*index): gain_p, gain_i, gain_d, integral_limit,
// angle_limit, straight_angle; gains are signed with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module line_follow_pid_steering import lfps_pkg::*; #(
  parameter int POS_BITS  = 10,
  parameter int FRAC_BITS = 12
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [((2*POS_BITS+7)/8)*8-1:0] in_tdata, // position, target
  input  wire logic                in_tuser,             // line_seen
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [ANGLE_W-1:0]       out_tdata,            // steer_angle
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [4:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  localparam int QW = 2 * POS_BITS + 3;

  cfg_t             cfg_r;
  reg_idx_t         idx;
  logic             wr_en;
  logic             q_push, q_pop, q_full, q_empty;
  logic [QW-1:0]    q_wdata, q_rdata;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= GAIN_P_RST;
      cfg_r.gain_i         <= GAIN_I_RST;
      cfg_r.gain_d         <= GAIN_D_RST;
      cfg_r.integral_limit <= ILIM_RST;
      cfg_r.angle_limit    <= ALIM_RST;
      cfg_r.straight_angle <= BASE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN_P:         cfg_r.gain_p         <= cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_I:         cfg_r.gain_i         <= cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_D:         cfg_r.gain_d         <= cfg_pwdata[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: cfg_r.integral_limit <= cfg_pwdata[LIM_W-1:0];
        REG_ANGLE_LIMIT:    cfg_r.angle_limit    <= cfg_pwdata[LIM_W-1:0];
        REG_STRAIGHT_ANGLE: cfg_r.straight_angle <= cfg_pwdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_P:         cfg_prdata = {16'd0, cfg_r.gain_p};
      REG_GAIN_I:         cfg_prdata = {16'd0, cfg_r.gain_i};
      REG_GAIN_D:         cfg_prdata = {16'd0, cfg_r.gain_d};
      REG_INTEGRAL_LIMIT: cfg_prdata = {24'd0, cfg_r.integral_limit};
      REG_ANGLE_LIMIT:    cfg_prdata = {24'd0, cfg_r.angle_limit};
      REG_STRAIGHT_ANGLE: cfg_prdata = {24'd0, cfg_r.straight_angle};
      default:            cfg_prdata = '0;
    endcase
  end

  lfps_front #(
    .POS_BITS (POS_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .line_seen (in_tuser),
    .position  (in_tdata[POS_BITS-1:0]),
    .target    (in_tdata[2*POS_BITS-1:POS_BITS]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  lfps_fifo #(
    .WIDTH (QW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  lfps_back #(
    .POS_BITS  (POS_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_empty     (q_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .steer_angle (out_tdata)
  );

endmodule
`default_nettype wire
